// ----- sv/spl_pkg.sv -----
`timescale 1ns / 1ps

package spl_pkg;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    // most words a single list command returns
    localparam int RESULT_LIMIT = 16;

    typedef struct packed {
        logic [1:0]         command;
        logic [63:0]        key;
        logic signed [31:0] priority_req;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [63:0]        entry_key;
        logic signed [31:0] entry_priority;
        logic               is_last;
    } out_word_t;

    // what the whole row of cells does in one cycle
    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_INSERT,
        MODE_DELETE,
        MODE_ROTATE
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t         mode;
        logic [63:0]        key;
        logic signed [31:0] prio;
    } cell_ctl_t;

    // contents and status one cell shows its neighbors
    typedef struct packed {
        logic [63:0]        key;
        logic signed [31:0] prio;
        logic               valid;
        logic               keep;
    } cell_link_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_DELETE,
        ST_LIST
    } seq_state_t;

endpackage

// ----- sv/spl_cell.sv -----
`timescale 1ns / 1ps

module spl_cell
    import spl_pkg::*;
(
    input  logic       aclk,
    input  cell_ctl_t  ctl,
    input  logic       valid_in,
    input  cell_link_t prev_link,
    input  cell_link_t next_link,
    input  logic       hole_in,
    output cell_link_t self_link,
    output logic       hole_out
);

    logic [63:0]        key_reg;
    logic [63:0]        key_next;
    logic signed [31:0] prio_reg;
    logic signed [31:0] prio_next;
    logic               keep;
    logic               match;

    // compare against the word in flight
    assign keep     = valid_in && (prio_reg >= ctl.prio);
    assign match    = valid_in && (key_reg == ctl.key);
    assign hole_out = hole_in || match;

    assign self_link.key   = key_reg;
    assign self_link.prio  = prio_reg;
    assign self_link.valid = valid_in;
    assign self_link.keep  = keep;

    // pick the next contents from self, new entry or a neighbor
    always_comb begin
        key_next  = key_reg;
        prio_next = prio_reg;
        case (ctl.mode)
            MODE_INSERT: begin
                if (!keep) begin
                    if (prev_link.keep) begin
                        key_next  = ctl.key;
                        prio_next = ctl.prio;
                    end else begin
                        key_next  = prev_link.key;
                        prio_next = prev_link.prio;
                    end
                end
            end
            MODE_DELETE: begin
                if (hole_out) begin
                    key_next  = next_link.key;
                    prio_next = next_link.prio;
                end
            end
            MODE_ROTATE: begin
                key_next  = next_link.key;
                prio_next = next_link.prio;
            end
            default: begin
                key_next  = key_reg;
                prio_next = prio_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        prio_reg <= prio_next;
    end

endmodule

// ----- sv/sorted_priority_list.sv -----
`timescale 1ns / 1ps

// Sorted priority list: up to CAPACITY entries (64-bit key, signed 32-bit
// priority) held in a row of cells in descending priority order, equal
// priorities in arrival order. Insert is accepted, then all cells shift in
// parallel. Delete removes every matching entry: each cycle the row closes
// the gap of the first match. List rotates the whole row once through its
// head cell, emitting one word per entry (at most 16) with is_last on the
// final one, or a single empty status word. One command is worked on at a
// time; the result word sits in an output register, and stalls on m_ready
// only hold the sequencer.
module sorted_priority_list
    import spl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(CAPACITY);
    localparam int EW = SW + 1;
    localparam int EMIT_MAX = (CAPACITY < RESULT_LIMIT) ? CAPACITY : RESULT_LIMIT;

    seq_state_t         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [SW-1:0]      step_reg, step_next;
    logic               found_reg, found_next;
    logic [63:0]        key_reg, key_next;
    logic signed [31:0] prio_reg, prio_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_reg, out_next;

    cell_ctl_t          ctl;
    cell_link_t         links [CAPACITY];
    logic [CAPACITY:0]  holes;

    logic               out_free;
    logic               any_match;
    logic [CW-1:0]      emit_num;
    logic               emit_now;
    logic               emit_last;
    logic               last_step;

    // row of cells
    assign holes[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            cell_link_t prev_l;
            cell_link_t next_l;
            logic       valid_l;

            assign valid_l = count_reg > CW'(gi);

            if (gi == 0) begin : g_head
                always_comb begin
                    prev_l      = links[0];
                    prev_l.keep = 1'b1;
                end
            end else begin : g_body
                assign prev_l = links[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign next_l = links[0];
            end else begin : g_inner
                assign next_l = links[gi+1];
            end

            spl_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .valid_in  (valid_l),
                .prev_link (prev_l),
                .next_link (next_l),
                .hole_in   (holes[gi]),
                .self_link (links[gi]),
                .hole_out  (holes[gi+1])
            );
        end
    endgenerate

    assign any_match = holes[CAPACITY];
    assign out_free  = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // list walk bookkeeping
    assign emit_num  = (count_reg > CW'(EMIT_MAX)) ? CW'(EMIT_MAX) : count_reg;
    assign emit_now  = EW'(step_reg) < EW'(emit_num);
    assign emit_last = (EW'(step_reg) + EW'(1)) == EW'(emit_num);
    assign last_step = step_reg == SW'(CAPACITY - 1);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        found_next     = found_reg;
        key_next       = key_reg;
        prio_next      = prio_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        ctl.mode       = MODE_HOLD;
        ctl.key        = key_reg;
        ctl.prio       = prio_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next   = s_data.key;
                    prio_next  = s_data.priority_req;
                    found_next = 1'b0;
                    step_next  = '0;
                    case (s_data.command)
                        CMD_INSERT: state_next = ST_INSERT;
                        CMD_DELETE: state_next = ST_DELETE;
                        CMD_LIST:   state_next = ST_LIST;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INSERT: begin
                if (out_free) begin
                    out_valid_next          = 1'b1;
                    out_next.entry_key      = '0;
                    out_next.entry_priority = '0;
                    out_next.is_last        = 1'b1;
                    if (count_reg == CW'(CAPACITY)) begin
                        out_next.status = STAT_FULL;
                    end else begin
                        out_next.status = STAT_OK;
                        ctl.mode        = MODE_INSERT;
                        count_next      = count_reg + CW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_DELETE: begin
                ctl.mode = MODE_DELETE;
                if (any_match) begin
                    count_next = count_reg - CW'(1);
                    found_next = 1'b1;
                end else if (out_free) begin
                    out_valid_next          = 1'b1;
                    out_next.status         = found_reg ? STAT_OK : STAT_NOT_FOUND;
                    out_next.entry_key      = '0;
                    out_next.entry_priority = '0;
                    out_next.is_last        = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            ST_LIST: begin
                if (count_reg == '0) begin
                    if (out_free) begin
                        out_valid_next          = 1'b1;
                        out_next.status         = STAT_EMPTY;
                        out_next.entry_key      = '0;
                        out_next.entry_priority = '0;
                        out_next.is_last        = 1'b1;
                        state_next              = ST_IDLE;
                    end
                end else if (!emit_now || out_free) begin
                    // head cell goes out while words remain to emit, row rotates by one
                    if (emit_now) begin
                        out_valid_next          = 1'b1;
                        out_next.status         = STAT_OK;
                        out_next.entry_key      = links[0].key;
                        out_next.entry_priority = links[0].prio;
                        out_next.is_last        = emit_last;
                    end
                    ctl.mode = MODE_ROTATE;
                    if (last_step) begin
                        step_next  = '0;
                        state_next = ST_IDLE;
                    end else begin
                        step_next = step_reg + SW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        prio_reg <= prio_next;
        out_reg  <= out_next;
    end

endmodule
